@@ rtl/core/audio_frame_header_decode_core_macros.svh @@
// Assertion macros for the audio frame header decoder.
// Each expects clk and rst_n in scope.
`ifndef AUDIO_FRAME_HEADER_DECODE_CORE_MACROS_SVH
`define AUDIO_FRAME_HEADER_DECODE_CORE_MACROS_SVH

// Same-cycle implication.
`define AFHD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define AFHD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/afhd_pkg.sv @@
// ----------------------------------------------------------------------------
// afhd_pkg
// Types, codes and lookup tables shared by the header decoder files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package afhd_pkg;

  typedef enum logic [1:0] {
    FMT_MPEG = 2'd0,
    FMT_AC3  = 2'd1,
    FMT_AAC  = 2'd2,
    FMT_RSVD = 2'd3
  } fmt_t;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_NO_SYNC   = 4'd1,
    ST_BAD_LAYER = 4'd2,
    ST_BAD_RATE  = 4'd3,
    ST_BAD_BR    = 4'd4,
    ST_AC3_BR    = 4'd5,
    ST_AC3_RATE  = 4'd6,
    ST_AAC_RATE  = 4'd7,
    ST_AAC_CHAN  = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    DIV_NONE = 2'd0,
    DIV_3    = 2'd1,
    DIV_49   = 2'd2,
    DIV_147  = 2'd3
  } div_sel_t;

  localparam logic [2:0] LAYER_AC3 = 3'd4;
  localparam logic [2:0] LAYER_AAC = 3'd5;

  localparam int RECIP_SHIFT = 26;
  localparam logic [24:0] RECIP_3   = 25'd22369621;
  localparam logic [24:0] RECIP_49  = 25'd1369568;
  localparam logic [24:0] RECIP_147 = 25'd456522;

  typedef struct packed {
    logic [3:0]  status;
    logic [12:0] mul_a;
    logic [16:0] mul_b;
    logic        pre_shift;
    div_sel_t    div_sel;
    logic [1:0]  post_shift;
    logic        add_bit;
    logic [1:0]  scale_shift;
    logic        to_br;
    logic [12:0] fb_direct;
    logic [22:0] br_direct;
    logic [16:0] sr;
    logic [3:0]  ch;
    logic [2:0]  layer;
    logic        pad;
    logic [12:0] spf;
  } dec_t;

  function automatic logic [8:0] mpa_kbps(input logic lsf, input logic [1:0] lay,
                                          input logic [3:0] idx);
    logic [8:0] k;
    k = 9'd0;
    if (!lsf && lay == 2'd0) begin
      case (idx)
        4'd1: k = 9'd32;   4'd2: k = 9'd64;   4'd3: k = 9'd96;   4'd4: k = 9'd128;
        4'd5: k = 9'd160;  4'd6: k = 9'd192;  4'd7: k = 9'd224;  4'd8: k = 9'd256;
        4'd9: k = 9'd288;  4'd10: k = 9'd320; 4'd11: k = 9'd352; 4'd12: k = 9'd384;
        4'd13: k = 9'd416; 4'd14: k = 9'd448; default: k = 9'd0;
      endcase
    end else if (!lsf && lay == 2'd1) begin
      case (idx)
        4'd1: k = 9'd32;   4'd2: k = 9'd48;   4'd3: k = 9'd56;   4'd4: k = 9'd64;
        4'd5: k = 9'd80;   4'd6: k = 9'd96;   4'd7: k = 9'd112;  4'd8: k = 9'd128;
        4'd9: k = 9'd160;  4'd10: k = 9'd192; 4'd11: k = 9'd224; 4'd12: k = 9'd256;
        4'd13: k = 9'd320; 4'd14: k = 9'd384; default: k = 9'd0;
      endcase
    end else if (!lsf) begin
      case (idx)
        4'd1: k = 9'd32;   4'd2: k = 9'd40;   4'd3: k = 9'd48;   4'd4: k = 9'd56;
        4'd5: k = 9'd64;   4'd6: k = 9'd80;   4'd7: k = 9'd96;   4'd8: k = 9'd112;
        4'd9: k = 9'd128;  4'd10: k = 9'd160; 4'd11: k = 9'd192; 4'd12: k = 9'd224;
        4'd13: k = 9'd256; 4'd14: k = 9'd320; default: k = 9'd0;
      endcase
    end else if (lay == 2'd0) begin
      case (idx)
        4'd1: k = 9'd32;   4'd2: k = 9'd48;   4'd3: k = 9'd56;   4'd4: k = 9'd64;
        4'd5: k = 9'd80;   4'd6: k = 9'd96;   4'd7: k = 9'd112;  4'd8: k = 9'd128;
        4'd9: k = 9'd144;  4'd10: k = 9'd160; 4'd11: k = 9'd176; 4'd12: k = 9'd192;
        4'd13: k = 9'd224; 4'd14: k = 9'd256; default: k = 9'd0;
      endcase
    end else begin
      case (idx)
        4'd1: k = 9'd8;    4'd2: k = 9'd16;   4'd3: k = 9'd24;   4'd4: k = 9'd32;
        4'd5: k = 9'd40;   4'd6: k = 9'd48;   4'd7: k = 9'd56;   4'd8: k = 9'd64;
        4'd9: k = 9'd80;   4'd10: k = 9'd96;  4'd11: k = 9'd112; 4'd12: k = 9'd128;
        4'd13: k = 9'd144; 4'd14: k = 9'd160; default: k = 9'd0;
      endcase
    end
    return k;
  endfunction

  function automatic logic [9:0] a52_kbps(input logic [4:0] idx);
    logic [9:0] k;
    case (idx)
      5'd0: k = 10'd32;   5'd1: k = 10'd40;   5'd2: k = 10'd48;   5'd3: k = 10'd56;
      5'd4: k = 10'd64;   5'd5: k = 10'd80;   5'd6: k = 10'd96;   5'd7: k = 10'd112;
      5'd8: k = 10'd128;  5'd9: k = 10'd160;  5'd10: k = 10'd192; 5'd11: k = 10'd224;
      5'd12: k = 10'd256; 5'd13: k = 10'd320; 5'd14: k = 10'd384; 5'd15: k = 10'd448;
      5'd16: k = 10'd512; 5'd17: k = 10'd576; 5'd18: k = 10'd640;
      default: k = 10'd0;
    endcase
    return k;
  endfunction

  function automatic logic [16:0] adts_hz(input logic [3:0] idx);
    logic [16:0] h;
    case (idx)
      4'd0: h = 17'd96000;  4'd1: h = 17'd88200;  4'd2: h = 17'd64000;
      4'd3: h = 17'd48000;  4'd4: h = 17'd44100;  4'd5: h = 17'd32000;
      4'd6: h = 17'd24000;  4'd7: h = 17'd22050;  4'd8: h = 17'd16000;
      4'd9: h = 17'd12000;  4'd10: h = 17'd11025; 4'd11: h = 17'd8000;
      4'd12: h = 17'd7350;
      default: h = 17'd0;
    endcase
    return h;
  endfunction

  function automatic logic [3:0] adts_chans(input logic [2:0] idx);
    logic [3:0] c;
    case (idx)
      3'd7:    c = 4'd8;
      default: c = {1'b0, idx};
    endcase
    return c;
  endfunction

  function automatic logic [2:0] a52_chans(input logic [2:0] acmod);
    logic [2:0] c;
    case (acmod)
      3'd0: c = 3'd2; 3'd1: c = 3'd1; 3'd2: c = 3'd2; 3'd3: c = 3'd3;
      3'd4: c = 3'd3; 3'd5: c = 3'd4; 3'd6: c = 3'd4; default: c = 3'd5;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] a52_lfe_mask(input logic [2:0] acmod);
    logic [7:0] m;
    case (acmod) inside
      3'd0, 3'd1:        m = 8'h10;
      3'd5, 3'd7:        m = 8'h01;
      default:           m = 8'h04;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/core/audio_frame_header_decode_core.sv @@
// ----------------------------------------------------------------------------
// audio_frame_header_decode_core
// Four-stage pipelined decoder for MPEG audio, AC-3 and AAC ADTS headers.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_wr_en/cfg_wr_data write the stream format (0 MPEG, 1 AC-3, 2 ADTS);
//   write it only while the pipeline is empty.
//   Input channel in_*: seven frame-aligned header bytes per transfer.
//   Output channel out_*: one result per input transfer, in order.
//   The stages are decode/lookup, operand multiply, reciprocal
//   multiply, quotient correction and final assembly. Throughput is one
//   header per cycle while out_stall is low; the reciprocal multiplier is in stage 3.
//   When out_stall is high the last stage holds; a bubble in any stage is
//   still filled, so in_stall rises only once all four stages hold a result.
//   Synchronous reset empties the pipeline and sets the format to MPEG.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "audio_frame_header_decode_core_macros.svh"

module audio_frame_header_decode_core
  import afhd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_hdr_byte0,
  input  logic [7:0]  in_hdr_byte1,
  input  logic [7:0]  in_hdr_byte2,
  input  logic [7:0]  in_hdr_byte3,
  input  logic [7:0]  in_hdr_byte4,
  input  logic [7:0]  in_hdr_byte5,
  input  logic [7:0]  in_hdr_byte6,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic [12:0] out_frame_bytes,
  output logic [22:0] out_bit_rate_bps,
  output logic [16:0] out_sample_rate_hz,
  output logic [3:0]  out_channel_count,
  output logic [2:0]  out_layer_code,
  output logic        out_padding_bit,
  output logic [12:0] out_samples_per_frame
);

  logic [1:0]  fmt_r;
  dec_t        dec;
  logic        v1_r, v2_r, v3_r, v4_r;
  logic        adv1, adv2, adv3, adv4;
  dec_t        d1_r, d2_r, d3_r;
  logic [29:0] prod2;
  logic [22:0] p2_r, p3_r;
  logic [24:0] recip;
  logic [47:0] prod3;
  logic [22:0] q0_nxt, q0_r;
  logic [7:0]  dval;
  logic [24:0] qd, rem;
  logic [22:0] q1, qs;
  logic [13:0] fsum;
  logic [12:0] fb_nxt;
  logic [22:0] br_nxt;
  logic [3:0]  st4_r;
  logic [12:0] fb4_r, spf4_r;
  logic [22:0] br4_r;
  logic [16:0] sr4_r;
  logic [3:0]  ch4_r;
  logic [2:0]  lay4_r;
  logic        pad4_r;

  assign adv4     = !v4_r || !out_stall;
  assign adv3     = !v3_r || adv4;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_MPEG;
    end else if (cfg_wr_en) begin
      fmt_r <= cfg_wr_data;
    end
  end

  afhd_hdr_decode u_dec (
    .fmt (fmt_r),
    .b0  (in_hdr_byte0),
    .b1  (in_hdr_byte1),
    .b2  (in_hdr_byte2),
    .b3  (in_hdr_byte3),
    .b4  (in_hdr_byte4),
    .b5  (in_hdr_byte5),
    .b6  (in_hdr_byte6),
    .dec (dec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  assign prod2 = 30'(d1_r.mul_a) * 30'(d1_r.mul_b);

  always_comb begin
    case (d2_r.div_sel)
      DIV_3:   recip = RECIP_3;
      DIV_49:  recip = RECIP_49;
      DIV_147: recip = RECIP_147;
      default: recip = '0;
    endcase
    prod3  = 48'(p2_r) * 48'(recip);
    q0_nxt = (d2_r.div_sel == DIV_NONE) ? p2_r : prod3[RECIP_SHIFT +: 23];
  end

  always_comb begin
    case (d3_r.div_sel)
      DIV_3:   dval = 8'd3;
      DIV_49:  dval = 8'd49;
      DIV_147: dval = 8'd147;
      default: dval = 8'd1;
    endcase
    qd     = 25'(q0_r) * 25'(dval);
    rem    = 25'(p3_r) - qd;
    q1     = q0_r + 23'(rem >= 25'(dval));
    qs     = q1 >> d3_r.post_shift;
    fsum   = 14'(qs[12:0]) + 14'(d3_r.add_bit);
    fb_nxt = d3_r.to_br ? d3_r.fb_direct : 13'(fsum << d3_r.scale_shift);
    br_nxt = d3_r.to_br ? qs : d3_r.br_direct;
  end

  always_ff @(posedge clk) begin
    if (adv1) d1_r <= dec;
    if (adv2) begin
      d2_r <= d1_r;
      p2_r <= d1_r.pre_shift ? prod2[29:7] : prod2[22:0];
    end
    if (adv3) begin
      d3_r <= d2_r;
      p3_r <= p2_r;
      q0_r <= q0_nxt;
    end
    if (adv4) begin
      st4_r  <= d3_r.status;
      fb4_r  <= fb_nxt;
      br4_r  <= br_nxt;
      sr4_r  <= d3_r.sr;
      ch4_r  <= d3_r.ch;
      lay4_r <= d3_r.layer;
      pad4_r <= d3_r.pad;
      spf4_r <= d3_r.spf;
    end
  end

  assign out_valid             = v4_r;
  assign out_status            = st4_r;
  assign out_frame_bytes       = fb4_r;
  assign out_bit_rate_bps      = br4_r;
  assign out_sample_rate_hz    = sr4_r;
  assign out_channel_count     = ch4_r;
  assign out_layer_code        = lay4_r;
  assign out_padding_bit       = pad4_r;
  assign out_samples_per_frame = spf4_r;

  `AFHD_ASSERT_NOW(a_err_zero, out_valid && out_status != ST_OK, out_frame_bytes == 13'd0 && out_bit_rate_bps == 23'd0 && out_sample_rate_hz == 17'd0 && out_layer_code == 3'd0, "error result carries nonzero fields")
  `AFHD_ASSERT_NOW(a_stall_full, in_stall, v1_r && v2_r && v3_r && v4_r, "input stalled with a free stage")
  `AFHD_ASSERT_NEXT(a_stage_move, v3_r && adv4, v4_r, "stage 3 item lost on advance")
  `AFHD_ASSERT_NOW(a_ac3_spf, out_valid && out_layer_code == LAYER_AC3, out_samples_per_frame == 13'd1536 && out_status == ST_OK, "AC-3 result has wrong frame size")

endmodule

@@ rtl/core/afhd_hdr_decode.sv @@
// ----------------------------------------------------------------------------
// afhd_hdr_decode
// Sync check, field extraction and table lookup for one header; sets up
// the operands of the shared multiply and constant-divide path.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afhd_hdr_decode
  import afhd_pkg::*;
(
  input  logic [1:0] fmt,
  input  logic [7:0] b0,
  input  logic [7:0] b1,
  input  logic [7:0] b2,
  input  logic [7:0] b3,
  input  logic [7:0] b4,
  input  logic [7:0] b5,
  input  logic [7:0] b6,
  output dec_t       dec
);

  logic [2:0]  m_layer;
  logic        m_lsf;
  logic        m_ext;
  logic [1:0]  m_sri;
  logic [8:0]  m_kbps;
  logic [1:0]  m_exp;
  logic [16:0] m_base;
  logic [4:0]  a_code;
  logic [1:0]  a_rc;
  logic [9:0]  a_kbps;
  logic [2:0]  a_acmod;
  logic [1:0]  a_shift;
  logic [16:0] a_base;
  logic [16:0] c_sr;
  logic [3:0]  c_ch;
  logic [2:0]  c_blk;

  always_comb begin
    m_layer = 3'(3'd4 - {1'b0, b1[2:1]});
    m_lsf   = b1[4] ? ~b1[3] : 1'b1;
    m_ext   = ~b1[4];
    m_sri   = b2[3:2];
    m_kbps  = mpa_kbps(m_lsf, m_layer[1:0] - 2'd1, b2[7:4]);
    m_exp   = (m_layer == 3'd3) ? {1'b0, m_ext} : 2'({1'b0, m_lsf} + {1'b0, m_ext});
    case (m_sri)
      2'd0:    m_base = 17'd44100;
      2'd1:    m_base = 17'd48000;
      default: m_base = 17'd32000;
    endcase

    a_code  = b4[5:1];
    a_rc    = b4[7:6];
    a_kbps  = a52_kbps(a_code);
    a_acmod = b6[7:5];
    case (b5[6:3])
      4'd9:    a_shift = 2'd1;
      4'd10:   a_shift = 2'd2;
      4'd11:   a_shift = 2'd3;
      default: a_shift = 2'd0;
    endcase
    case (a_rc)
      2'd0:    a_base = 17'd48000;
      2'd1:    a_base = 17'd44100;
      default: a_base = 17'd32000;
    endcase

    c_sr  = adts_hz(b2[5:2]);
    c_ch  = adts_chans({b2[0], b3[7:6]});
    c_blk = {1'b0, b6[1:0]} + 3'd1;

    dec        = '0;
    dec.status = ST_OK;

    unique case (fmt_t'(fmt))
      FMT_MPEG: begin
        if (b0 != 8'hFF || b1[7:5] != 3'b111) begin
          dec.status = ST_NO_SYNC;
        end else if (m_layer == 3'd4) begin
          dec.status = ST_BAD_LAYER;
        end else if (m_sri == 2'd3) begin
          dec.status = ST_BAD_RATE;
        end else if (m_kbps == 9'd0) begin
          dec.status = ST_BAD_BR;
        end else begin
          dec.mul_a = {4'd0, m_kbps};
          if (m_layer == 3'd1) begin
            dec.scale_shift = 2'd2;
            unique case (m_sri)
              2'd1: begin
                dec.mul_b = 17'(17'd1 << m_exp);
                dec.post_shift = 2'd2;
              end
              2'd2: begin
                dec.mul_b = 17'(17'd3 << m_exp);
                dec.post_shift = 2'd3;
              end
              default: begin
                dec.mul_b = 17'(17'd40 << m_exp);
                dec.div_sel = DIV_147;
              end
            endcase
            dec.spf = 13'd384;
          end else begin
            unique case (m_sri)
              2'd1: begin
                dec.mul_b = 17'(17'd3 << m_exp);
              end
              2'd2: begin
                dec.mul_b = 17'(17'd9 << m_exp);
                dec.post_shift = 2'd1;
              end
              default: begin
                dec.mul_b = 17'(17'd160 << m_exp);
                dec.div_sel = DIV_49;
              end
            endcase
            dec.spf = (m_layer == 3'd3 && m_lsf) ? 13'd576 : 13'd1152;
          end
          dec.add_bit   = b2[1];
          dec.br_direct = 23'(m_kbps) * 23'd1000;
          dec.sr        = m_base >> (2'({1'b0, m_lsf} + {1'b0, m_ext}));
          dec.ch        = (b3[7:6] == 2'd3) ? 4'd1 : 4'd2;
          dec.layer     = m_layer;
          dec.pad       = b2[1];
        end
      end
      FMT_AC3: begin
        if (b0 != 8'h0B || b1 != 8'h77) begin
          dec.status = ST_NO_SYNC;
        end else if (a_code >= 5'd19) begin
          dec.status = ST_AC3_BR;
        end else if (a_rc == 2'd3) begin
          dec.status = ST_AC3_RATE;
        end else begin
          dec.mul_a = {3'd0, a_kbps};
          unique case (a_rc)
            2'd0:    dec.mul_b = 17'd4;
            2'd2:    dec.mul_b = 17'd6;
            default: begin
              dec.mul_b       = 17'd320;
              dec.div_sel     = DIV_147;
              dec.add_bit     = b4[0];
              dec.scale_shift = 2'd1;
            end
          endcase
          dec.br_direct = 23'(a_kbps) * 23'd1000;
          dec.sr        = a_base >> a_shift;
          dec.ch        = {1'b0, a52_chans(a_acmod)}
                          + {3'd0, (b6 & a52_lfe_mask(a_acmod)) != 8'd0};
          dec.layer     = LAYER_AC3;
          dec.spf       = 13'd1536;
        end
      end
      FMT_AAC: begin
        if (b0 != 8'hFF || b1[7:4] != 4'hF) begin
          dec.status = ST_NO_SYNC;
        end else if (c_sr == 17'd0) begin
          dec.status = ST_AAC_RATE;
        end else if (c_ch == 4'd0) begin
          dec.status = ST_AAC_CHAN;
        end else begin
          dec.fb_direct = {b3[1:0], b4, b5[7:5]};
          dec.mul_a     = {b3[1:0], b4, b5[7:5]};
          dec.mul_b     = c_sr;
          dec.pre_shift = 1'b1;
          dec.to_br     = 1'b1;
          case (c_blk)
            3'd2:    dec.post_shift = 2'd1;
            3'd3:    dec.div_sel = DIV_3;
            3'd4:    dec.post_shift = 2'd2;
            default: dec.post_shift = 2'd0;
          endcase
          dec.sr    = c_sr;
          dec.ch    = c_ch;
          dec.layer = LAYER_AAC;
          dec.spf   = 13'({c_blk, 10'd0});
        end
      end
      default: dec.status = ST_NO_SYNC;
    endcase
  end

endmodule

@@ test/tb_audio_frame_header_decode_core.sv @@
// ----------------------------------------------------------------------------
// tb_audio_frame_header_decode_core
// Drives MPEG, AC-3 and ADTS headers into the decoder under random
// stalls and gaps. An in-bench decoder predicts each result, and the
// bench compares every field in transfer order. The stream format is
// switched between phases once the pipeline has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_audio_frame_header_decode_core;
  import afhd_pkg::*;

  typedef struct {
    logic [3:0]  status;
    logic [12:0] frame_bytes;
    logic [22:0] br_bps;
    logic [16:0] sr_hz;
    logic [3:0]  channels;
    logic [2:0]  layer;
    logic        pad;
    logic [12:0] spf;
  } hdr_info_t;

  typedef logic [7:0] hdr_bytes_t [7];

  localparam int MPA_KBPS [2][3][16] = '{
    '{'{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
      '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
      '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0}},
    '{'{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
      '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
      '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}}};
  localparam int MPA_HZ [3] = '{44100, 48000, 32000};
  localparam int AC3_KBPS [19] = '{32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192,
                                    224, 256, 320, 384, 448, 512, 576, 640};
  localparam int AC3_HZ [3] = '{48000, 44100, 32000};
  localparam int AC3_CH [8] = '{2, 1, 2, 3, 3, 4, 4, 5};
  localparam int AC3_LFE [8] = '{'h10, 'h10, 'h04, 'h04, 'h04, 'h01, 'h04, 'h01};
  localparam int ADTS_HZ [16] = '{96000, 88200, 64000, 48000, 44100, 32000, 24000,
                                   22050, 16000, 12000, 11025, 8000, 7350, 0, 0, 0};
  localparam int ADTS_CH [8] = '{0, 1, 2, 3, 4, 5, 6, 8};

  function automatic hdr_info_t decode_header(fmt_t fmt, hdr_bytes_t b);
    hdr_info_t r;
    longint kbps, sr, fb, br, bri, lsf, ext, layer, code, rc, acmod, ch, blocks, bsid;
    longint spf;
    r = '{default: '0};
    r.status = ST_OK;
    case (fmt)
      FMT_MPEG: begin
        layer = 4 - b[1][2:1];
        if (b[0] != 8'hFF || b[1][7:5] != 3'b111) r.status = ST_NO_SYNC;
        else if (layer > 3) r.status = ST_BAD_LAYER;
        else if (b[2][3:2] == 2'd3) r.status = ST_BAD_RATE;
        else begin
          if (b[1][4]) begin
            lsf = b[1][3] ? 0 : 1;
            ext = 0;
          end else begin
            lsf = 1;
            ext = 1;
          end
          sr = MPA_HZ[b[2][3:2]] >> (lsf + ext);
          bri = b[2][7:4];
          kbps = MPA_KBPS[lsf][layer - 1][bri];
          if (kbps == 0) r.status = ST_BAD_BR;
          else begin
            if (layer == 1) begin
              fb = ((kbps * 12000) / sr + b[2][1]) * 4;
              r.spf = 13'd384;
            end else if (layer == 2) begin
              fb = (kbps * 144000) / sr + b[2][1];
              r.spf = 13'd1152;
            end else begin
              fb = (kbps * 144000) / (sr << lsf) + b[2][1];
              r.spf = lsf ? 13'd576 : 13'd1152;
            end
            r.frame_bytes = fb[12:0];
            br = kbps * 1000;
            r.br_bps = br[22:0];
            r.sr_hz = sr[16:0];
            r.channels = (b[3][7:6] == 2'd3) ? 4'd1 : 4'd2;
            r.layer = layer[2:0];
            r.pad = b[2][1];
          end
        end
      end
      FMT_AC3: begin
        code = b[4][5:0];
        rc = b[4][7:6];
        if (b[0] != 8'h0B || b[1] != 8'h77) r.status = ST_NO_SYNC;
        else if ((code >> 1) >= 19) r.status = ST_AC3_BR;
        else if (rc == 3) r.status = ST_AC3_RATE;
        else begin
          br = AC3_KBPS[code >> 1] * 1000;
          if (rc == 0) fb = 4 * (br / 1000);
          else if (rc == 1) fb = 2 * ((320 * br) / 147000 + (code & 1));
          else fb = 6 * (br / 1000);
          acmod = b[6][7:5];
          ch = AC3_CH[acmod];
          if ((b[6] & AC3_LFE[acmod]) != 0) ch++;
          bsid = b[5][6:3];
          sr = AC3_HZ[rc];
          if (bsid >= 9 && bsid <= 11) sr = sr >> (bsid - 8);
          r.frame_bytes = fb[12:0];
          r.br_bps = br[22:0];
          r.sr_hz = sr[16:0];
          r.channels = ch[3:0];
          r.layer = LAYER_AC3;
          r.spf = 13'd1536;
        end
      end
      FMT_AAC: begin
        sr = ADTS_HZ[b[2][5:2]];
        ch = ADTS_CH[{b[2][0], b[3][7:6]}];
        if (b[0] != 8'hFF || b[1][7:4] != 4'hF) r.status = ST_NO_SYNC;
        else if (sr == 0) r.status = ST_AAC_RATE;
        else if (ch == 0) r.status = ST_AAC_CHAN;
        else begin
          fb = {b[3][1:0], b[4], b[5][7:5]};
          blocks = b[6][1:0] + 1;
          br = (fb * 8 * sr) / (1024 * blocks);
          spf = 1024 * blocks;
          r.frame_bytes = fb[12:0];
          r.br_bps = br[22:0];
          r.sr_hz = sr[16:0];
          r.channels = ch[3:0];
          r.layer = LAYER_AAC;
          r.spf = spf[12:0];
        end
      end
      default: r.status = ST_NO_SYNC;
    endcase
    return r;
  endfunction

  class header_scoreboard;
    fmt_t      fmt = FMT_MPEG;
    hdr_info_t pending[$];
    int        errors = 0;

    function void note_header(hdr_bytes_t b);
      pending.push_back(decode_header(fmt, b));
    endfunction

    task report(string what, longint got, longint want);
      $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(hdr_info_t got);
      hdr_info_t want;
      if (pending.size() == 0) begin
        report("unexpected result, status", got.status, -1);
      end else begin
        want = pending.pop_front();
        if (got.status !== want.status) report("status", got.status, want.status);
        if (got.frame_bytes !== want.frame_bytes)
          report("frame_bytes", got.frame_bytes, want.frame_bytes);
        if (got.br_bps !== want.br_bps) report("bits per second", got.br_bps, want.br_bps);
        if (got.sr_hz !== want.sr_hz)
          report("sampling frequency", got.sr_hz, want.sr_hz);
        if (got.channels !== want.channels) report("channels", got.channels, want.channels);
        if (got.layer !== want.layer) report("layer", got.layer, want.layer);
        if (got.pad !== want.pad) report("padding", got.pad, want.pad);
        if (got.spf !== want.spf) report("samples_per_frame", got.spf, want.spf);
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_b [7] = '{default: 8'h00};
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_status;
  logic [12:0] out_frame_bytes;
  logic [22:0] out_bit_rate_bps;
  logic [16:0] out_sample_rate_hz;
  logic [3:0]  out_channel_count;
  logic [2:0]  out_layer_code;
  logic        out_padding_bit;
  logic [12:0] out_samples_per_frame;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  header_scoreboard sb = new();

  audio_frame_header_decode_core i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_hdr_byte0          (in_b[0]),
    .in_hdr_byte1          (in_b[1]),
    .in_hdr_byte2          (in_b[2]),
    .in_hdr_byte3          (in_b[3]),
    .in_hdr_byte4          (in_b[4]),
    .in_hdr_byte5          (in_b[5]),
    .in_hdr_byte6          (in_b[6]),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_frame_bytes       (out_frame_bytes),
    .out_bit_rate_bps      (out_bit_rate_bps),
    .out_sample_rate_hz    (out_sample_rate_hz),
    .out_channel_count     (out_channel_count),
    .out_layer_code        (out_layer_code),
    .out_padding_bit       (out_padding_bit),
    .out_samples_per_frame (out_samples_per_frame)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    hdr_info_t got;
    hdr_bytes_t b;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        for (int i = 0; i < 7; i++) b[i] = in_b[i];
        sb.note_header(b);
      end
      if (out_valid && !out_stall) begin
        got.status = out_status;
        got.frame_bytes = out_frame_bytes;
        got.br_bps = out_bit_rate_bps;
        got.sr_hz = out_sample_rate_hz;
        got.channels = out_channel_count;
        got.layer = out_layer_code;
        got.pad = out_padding_bit;
        got.spf = out_samples_per_frame;
        sb.check_result(got);
      end
    end
  end

  task automatic send_header(hdr_bytes_t b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int i = 0; i < 7; i++) in_b[i] <= b[i];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_format(fmt_t f);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= f;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.fmt = f;
  endtask

  function automatic hdr_bytes_t make_header(fmt_t f);
    hdr_bytes_t b;
    for (int i = 0; i < 7; i++) b[i] = 8'($urandom_range(255));
    if ($urandom_range(99) < 12) return b;
    case (f)
      FMT_MPEG: begin
        b[0] = 8'hFF;
        b[1][7:5] = 3'b111;
        if ($urandom_range(9) != 0) b[1][2:1] = 2'($urandom_range(3, 1));
        if ($urandom_range(9) != 0) b[2][3:2] = 2'($urandom_range(2));
        if ($urandom_range(9) != 0) b[2][7:4] = 4'($urandom_range(14, 1));
      end
      FMT_AC3: begin
        b[0] = 8'h0B;
        b[1] = 8'h77;
        if ($urandom_range(9) != 0) b[4][5:0] = 6'($urandom_range(37));
        if ($urandom_range(9) != 0) b[4][7:6] = 2'($urandom_range(2));
        if ($urandom_range(3) == 0) b[5][6:3] = 4'($urandom_range(11, 9));
      end
      default: begin
        b[0] = 8'hFF;
        b[1][7:4] = 4'hF;
        if ($urandom_range(9) != 0) b[2][5:2] = 4'($urandom_range(12));
        if ($urandom_range(9) != 0 && {b[2][0], b[3][7:6]} == 3'd0) b[3][6] = 1'b1;
      end
    endcase
    return b;
  endfunction

  initial begin
    fmt_t phase_fmt [9];
    phase_fmt = '{FMT_MPEG, FMT_AC3, FMT_AAC, FMT_AAC, FMT_MPEG, FMT_AC3,
                  FMT_AC3, FMT_AAC, FMT_MPEG};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_format(FMT_MPEG);
    send_header('{8'hFF, 8'hFB, 8'h90, 8'hC4, 8'h00, 8'h00, 8'h00}); // layer III, mono
    send_header('{8'hFF, 8'hFF, 8'hE2, 8'h00, 8'h00, 8'h00, 8'h00}); // layer I, max rate, pad
    send_header('{8'hFF, 8'hE3, 8'h18, 8'h00, 8'h00, 8'h00, 8'h00}); // v2.5 layer III
    send_header('{8'hFF, 8'hF5, 8'hF0, 8'h00, 8'h00, 8'h00, 8'h00}); // reserved bit rate
    send_header('{8'hFF, 8'hFD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}); // free format
    send_header('{8'hFF, 8'hF9, 8'h90, 8'h00, 8'h00, 8'h00, 8'h00}); // layer zero
    send_header('{8'hFF, 8'hFB, 8'h9C, 8'h00, 8'h00, 8'h00, 8'h00}); // rate index 3
    send_header('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}); // no sync

    set_format(FMT_AC3);
    send_header('{8'h0B, 8'h77, 8'h00, 8'h00, 8'h43, 8'h48, 8'hFF}); // 44.1k odd code, bsid 9
    send_header('{8'h0B, 8'h77, 8'h00, 8'h00, 8'h25, 8'h50, 8'h10}); // 640k, bsid 10, LFE
    send_header('{8'h0B, 8'h77, 8'h00, 8'h00, 8'h80, 8'h58, 8'hA4}); // 32k, bsid 11
    send_header('{8'h0B, 8'h77, 8'h00, 8'h00, 8'h26, 8'h00, 8'h00}); // reserved bit rate
    send_header('{8'h0B, 8'h77, 8'h00, 8'h00, 8'hC0, 8'h00, 8'h00}); // reserved rate code

    set_format(FMT_AAC);
    send_header('{8'hFF, 8'hF1, 8'h01, 8'hC3, 8'hFF, 8'hFF, 8'hFF}); // max length, 96k, 8 ch
    send_header('{8'hFF, 8'hF9, 8'h30, 8'h80, 8'h00, 8'h00, 8'h00}); // zero length, 7350
    send_header('{8'hFF, 8'hF1, 8'h34, 8'h40, 8'h00, 8'h00, 8'h00}); // rate index 13
    send_header('{8'hFF, 8'hF1, 8'h3C, 8'h40, 8'h00, 8'h00, 8'h00}); // rate index 15
    send_header('{8'hFF, 8'hF1, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00}); // channel config zero
    send_header('{8'hFF, 8'hE1, 8'h10, 8'h40, 8'h00, 8'h00, 8'h00}); // no sync

    set_format(FMT_RSVD);
    send_header('{8'hFF, 8'hFB, 8'h90, 8'hC4, 8'h00, 8'h00, 8'h00});
    send_header('{8'h0B, 8'h77, 8'h00, 8'h00, 8'h43, 8'h48, 8'hFF});

    for (int p = 0; p < 9; p++) begin
      set_format(phase_fmt[p]);
      send_idle_pct = (p < 3) ? 22 : (p < 6) ? 47 : 0;
      recv_idle_pct = (p < 3) ? 47 : (p < 6) ? 22 : 0;
      for (int n = 0; n < 84; n++) begin
        if (p == 4 && n == 40) drain();
        send_header(make_header(phase_fmt[p]));
      end
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_audio_frame_header_decode_core: PASS");
    end else begin
      $display("tb_audio_frame_header_decode_core: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_audio_frame_header_decode_core: FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/afhd_pkg.sv
rtl/core/afhd_hdr_decode.sv
rtl/core/audio_frame_header_decode_core.sv
test/tb_audio_frame_header_decode_core.sv
